FILE: rtl/core/vhm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhm_pkg
// Shared types, constants and helpers of the virtual host matcher.
// ----------------------------------------------------------------------------
package vhm_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int MAX_LEN_DEF     = 256;

	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_RBRK  = 8'h5d;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5a;
	localparam logic [7:0] CASE_OFS = 8'h20;

	typedef enum logic [2:0] {
		OC_ADDED     = 3'd0,
		OC_FULL      = 3'd1,
		OC_BAD_LEN   = 3'd2,
		OC_EXACT     = 3'd3,
		OC_WILDCARD  = 3'd4,
		OC_DEFAULT   = 3'd5,
		OC_NOT_FOUND = 3'd6
	} outcome_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_META_RD,
		S_META,
		S_BYTE_RD,
		S_BYTE,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_byte;
		logic       byte_valid;
		logic       last;
	} req_t;

	typedef struct packed {
		outcome_t   outcome;
		logic [3:0] entry_index;
		logic [4:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		outcome_t   outcome;
		logic [3:0] entry_index;
	} seq_res_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		fold = (c >= CH_UC_A && c <= CH_UC_Z) ? c + CASE_OFS : c;
	endfunction

endpackage

FILE: rtl/core/virtual_host_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_host_matcher_core
// Host pattern table with exact and wildcard-suffix lookup.
//
// req channel (req_valid/req_stall/req_word) carries one character per word;
// req_type selects pattern add or host lookup, last closes the string.
// rsp channel (rsp_valid/rsp_stall/rsp_word) returns one word per closed
// string. cfg channel (cfg_valid/cfg_ready/cfg_data) sets default_present.
// A closing add word's result is registered and shown in the next cycle.
// A closing lookup holds req_stall while the compare sequencer walks
// the table, plain entries first and wildcard entries after, stopping at
// the first hit; the result word is registered from the sequencer's done
// state. The walk uses the single byte compare unit and one read port per
// memory. A closing word is held off while a previous result waits in
// rsp; other words still flow. Reset empties the table and host state; no
// memory clearing pass is run.
// ----------------------------------------------------------------------------
module virtual_host_matcher_core #(
	parameter int MAX_ENTRIES = vhm_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_LEN     = vhm_pkg::MAX_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  vhm_pkg::req_t  req_word,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output vhm_pkg::rsp_t  rsp_word,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int BW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic              default_present_q;
	logic [CW-1:0]     count_q;
	logic [LW-1:0]     add_len_q, host_len_q, bracket_q, colon_q;
	logic              star_q, dot_q, first_lb_q;
	logic              rsp_valid_q;
	vhm_pkg::rsp_t     rsp_q;

	logic              acc, is_add, is_host, full;
	logic [7:0]        c;
	logic [LW-1:0]     add_len_n, host_len_n, bracket_n, colon_n, look_len;
	logic              star_n, dot_n, first_lb_n, hbyte, add_ok, wc;
	logic              pat_we, meta_we, host_we;
	logic [IW-1:0]     meta_raddr;
	logic [BW-1:0]     meta_rlen, host_raddr;
	logic              meta_rwc;
	logic [IW+BW-1:0]  pat_raddr;
	logic [7:0]        pat_rdata, host_rdata;
	vhm_pkg::seq_res_t seq_res;

	assign cfg_ready = 1'b1;
	assign req_stall = seq_res.busy || (rsp_valid_q && req_word.last);
	assign acc       = req_valid && !req_stall;
	assign is_add    = acc && !req_word.req_type;
	assign is_host   = acc && req_word.req_type;
	assign c         = req_word.char_byte;
	assign full      = (count_q >= CW'(MAX_ENTRIES));

	assign pat_we    = is_add && req_word.byte_valid && !full && (add_len_q < LW'(MAX_LEN));
	assign add_len_n = (req_word.byte_valid && add_len_q < LW'(MAX_LEN))
	                   ? add_len_q + LW'(1) : add_len_q;
	assign star_n    = (req_word.byte_valid && add_len_q == LW'(0)) ? (c == vhm_pkg::CH_STAR)
	                   : star_q;
	assign dot_n     = (req_word.byte_valid && add_len_q == LW'(1)) ? (c == vhm_pkg::CH_DOT)
	                   : dot_q;
	assign add_ok    = !full && add_len_n != '0 && add_len_n < LW'(MAX_LEN);
	assign wc        = add_len_n >= LW'(2) && star_n && dot_n;
	assign meta_we   = is_add && req_word.last && add_ok;

	assign hbyte      = req_word.byte_valid && host_len_q < LW'(MAX_LEN);
	assign host_we    = is_host && hbyte;
	assign host_len_n = hbyte ? host_len_q + LW'(1) : host_len_q;
	assign bracket_n  = (hbyte && c == vhm_pkg::CH_RBRK && bracket_q == '0)
	                    ? host_len_q + LW'(1) : bracket_q;
	assign colon_n    = (hbyte && c == vhm_pkg::CH_COLON) ? host_len_q + LW'(1) : colon_q;
	assign first_lb_n = (hbyte && host_len_q == '0) ? (c == vhm_pkg::CH_LBRK) : first_lb_q;

	always_comb begin
		look_len = host_len_n;
		if (host_len_n != '0) begin
			if (first_lb_n) begin
				if (bracket_n != '0) look_len = bracket_n;
			end else if (colon_n != '0) begin
				look_len = colon_n - LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_present_q <= 1'b0;
			count_q           <= '0;
			add_len_q         <= '0;
			host_len_q        <= '0;
			bracket_q         <= '0;
			colon_q           <= '0;
			rsp_valid_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) default_present_q <= cfg_data;
			if (is_add) begin
				add_len_q <= req_word.last ? '0 : add_len_n;
				if (meta_we) count_q <= count_q + CW'(1);
			end
			if (is_host) begin
				host_len_q <= req_word.last ? '0 : host_len_n;
				bracket_q  <= req_word.last ? '0 : bracket_n;
				colon_q    <= req_word.last ? '0 : colon_n;
			end
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			if ((is_add && req_word.last) || seq_res.done) rsp_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (is_add) begin
			star_q <= star_n;
			dot_q  <= dot_n;
			if (req_word.last) begin
				rsp_q.entry_count <= 5'(meta_we ? count_q + CW'(1) : count_q);
				if (full) begin
					rsp_q.outcome     <= vhm_pkg::OC_FULL;
					rsp_q.entry_index <= '0;
				end else if (!add_ok) begin
					rsp_q.outcome     <= vhm_pkg::OC_BAD_LEN;
					rsp_q.entry_index <= '0;
				end else begin
					rsp_q.outcome     <= vhm_pkg::OC_ADDED;
					rsp_q.entry_index <= 4'(count_q);
				end
			end
		end
		if (is_host) first_lb_q <= first_lb_n;
		if (seq_res.done) begin
			rsp_q.outcome     <= seq_res.outcome;
			rsp_q.entry_index <= seq_res.entry_index;
			rsp_q.entry_count <= 5'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	vhm_store #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.MAX_LEN    (MAX_LEN)
	) u_store (
		.clk       (clk),
		.pat_we    (pat_we),
		.pat_waddr ({count_q[IW-1:0], add_len_q[BW-1:0]}),
		.pat_wdata (c),
		.pat_raddr (pat_raddr),
		.pat_rdata (pat_rdata),
		.meta_we   (meta_we),
		.meta_waddr(count_q[IW-1:0]),
		.meta_wlen (add_len_n[BW-1:0]),
		.meta_wwc  (wc),
		.meta_raddr(meta_raddr),
		.meta_rlen (meta_rlen),
		.meta_rwc  (meta_rwc),
		.host_we   (host_we),
		.host_waddr(host_len_q[BW-1:0]),
		.host_wdata(c),
		.host_raddr(host_raddr),
		.host_rdata(host_rdata)
	);

	vhm_match_seq #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.MAX_LEN    (MAX_LEN)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (is_host && req_word.last),
		.lookup_len     (look_len),
		.count          (count_q),
		.default_present(default_present_q),
		.meta_raddr     (meta_raddr),
		.meta_rlen      (meta_rlen),
		.meta_rwc       (meta_rwc),
		.pat_raddr      (pat_raddr),
		.pat_rdata      (pat_rdata),
		.host_raddr     (host_raddr),
		.host_rdata     (host_rdata),
		.res            (seq_res)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> rsp_valid_q) else $error("result dropped");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES)) else $error("table overfilled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		seq_res.busy |-> !acc) else $error("word taken during lookup");

endmodule

FILE: rtl/core/vhm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhm_store
// Pattern bytes, per-entry length/wildcard table and host byte buffer.
// ----------------------------------------------------------------------------
module vhm_store #(
	parameter int MAX_ENTRIES = vhm_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_LEN     = vhm_pkg::MAX_LEN_DEF,
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int BW = $clog2(MAX_LEN)
) (
	input  logic                clk,
	input  logic                pat_we,
	input  logic [IW+BW-1:0]    pat_waddr,
	input  logic [7:0]          pat_wdata,
	input  logic [IW+BW-1:0]    pat_raddr,
	output logic [7:0]          pat_rdata,
	input  logic                meta_we,
	input  logic [IW-1:0]       meta_waddr,
	input  logic [BW-1:0]       meta_wlen,
	input  logic                meta_wwc,
	input  logic [IW-1:0]       meta_raddr,
	output logic [BW-1:0]       meta_rlen,
	output logic                meta_rwc,
	input  logic                host_we,
	input  logic [BW-1:0]       host_waddr,
	input  logic [7:0]          host_wdata,
	input  logic [BW-1:0]       host_raddr,
	output logic [7:0]          host_rdata
);

	logic [7:0]  pat_mem  [MAX_ENTRIES << BW];
	logic [BW:0] meta_mem [MAX_ENTRIES];
	logic [7:0]  host_mem [2**BW];

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[pat_waddr] <= pat_wdata;
		end
		pat_rdata <= pat_mem[pat_raddr];
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= {meta_wlen, meta_wwc};
		end
		{meta_rlen, meta_rwc} <= meta_mem[meta_raddr];
	end

	always_ff @(posedge clk) begin
		if (host_we) begin
			host_mem[host_waddr] <= host_wdata;
		end
		host_rdata <= host_mem[host_raddr];
	end

endmodule

FILE: rtl/core/vhm_match_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhm_match_seq
// Lookup sequencer: walks entries, one folded byte compare per step.
// ----------------------------------------------------------------------------
module vhm_match_seq #(
	parameter int MAX_ENTRIES = vhm_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_LEN     = vhm_pkg::MAX_LEN_DEF,
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int BW = $clog2(MAX_LEN),
	localparam int LW = $clog2(MAX_LEN + 1),
	localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [LW-1:0]       lookup_len,
	input  logic [CW-1:0]       count,
	input  logic                default_present,
	output logic [IW-1:0]       meta_raddr,
	input  logic [BW-1:0]       meta_rlen,
	input  logic                meta_rwc,
	output logic [IW+BW-1:0]    pat_raddr,
	input  logic [7:0]          pat_rdata,
	output logic [BW-1:0]       host_raddr,
	input  logic [7:0]          host_rdata,
	output vhm_pkg::seq_res_t   res
);

	vhm_pkg::seq_state_t state_q, state_d;
	logic                wild_q;
	logic [CW-1:0]       idx_q;
	logic [BW-1:0]       k_q, n_q;
	logic                pofs_q;
	logic [LW-1:0]       hofs_q, len_q;
	vhm_pkg::outcome_t   oc_q;
	logic [3:0]          hit_q;

	logic                end_of_list, cand, byte_eq, last_byte;
	logic [LW-1:0]       plen_w, sl_w;
	logic [BW-1:0]       pofs_k;
	logic [LW-1:0]       hsum;

	assign end_of_list = (idx_q >= count);
	assign plen_w      = LW'(meta_rlen);
	assign sl_w        = plen_w - LW'(1);
	assign cand        = wild_q ? (meta_rwc && len_q > sl_w)
	                            : (!meta_rwc && plen_w == len_q);
	assign byte_eq     = vhm_pkg::fold(pat_rdata) == vhm_pkg::fold(host_rdata);
	assign last_byte   = (k_q + BW'(1)) == n_q;
	assign pofs_k      = k_q + BW'(pofs_q);
	assign hsum        = hofs_q + LW'(k_q);

	assign meta_raddr = idx_q[IW-1:0];
	assign pat_raddr  = {idx_q[IW-1:0], pofs_k};
	assign host_raddr = hsum[BW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			vhm_pkg::S_IDLE: begin
				if (start) state_d = vhm_pkg::S_META_RD;
			end
			vhm_pkg::S_META_RD: state_d = vhm_pkg::S_META;
			vhm_pkg::S_META: begin
				if (end_of_list) begin
					state_d = wild_q ? vhm_pkg::S_DONE : vhm_pkg::S_META_RD;
				end else if (cand) begin
					state_d = vhm_pkg::S_BYTE_RD;
				end else begin
					state_d = vhm_pkg::S_META_RD;
				end
			end
			vhm_pkg::S_BYTE_RD: state_d = vhm_pkg::S_BYTE;
			vhm_pkg::S_BYTE: begin
				if (!byte_eq) state_d = vhm_pkg::S_META_RD;
				else if (last_byte) state_d = vhm_pkg::S_DONE;
				else state_d = vhm_pkg::S_BYTE_RD;
			end
			vhm_pkg::S_DONE: state_d = vhm_pkg::S_IDLE;
			default: state_d = vhm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		res.busy        = (state_q != vhm_pkg::S_IDLE);
		res.done        = (state_q == vhm_pkg::S_DONE);
		res.outcome     = oc_q;
		res.entry_index = hit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vhm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			vhm_pkg::S_IDLE: begin
				if (start) begin
					wild_q <= 1'b0;
					idx_q  <= '0;
					len_q  <= lookup_len;
				end
			end
			vhm_pkg::S_META: begin
				if (end_of_list) begin
					wild_q <= 1'b1;
					idx_q  <= '0;
					oc_q   <= default_present ? vhm_pkg::OC_DEFAULT : vhm_pkg::OC_NOT_FOUND;
					hit_q  <= '0;
				end else if (cand) begin
					k_q <= '0;
					if (wild_q) begin
						n_q    <= sl_w[BW-1:0];
						pofs_q <= 1'b1;
						hofs_q <= len_q - sl_w;
					end else begin
						n_q    <= meta_rlen;
						pofs_q <= 1'b0;
						hofs_q <= '0;
					end
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			vhm_pkg::S_BYTE: begin
				if (!byte_eq) begin
					idx_q <= idx_q + CW'(1);
				end else if (last_byte) begin
					oc_q  <= wild_q ? vhm_pkg::OC_WILDCARD : vhm_pkg::OC_EXACT;
					hit_q <= 4'(idx_q);
				end else begin
					k_q <= k_q + BW'(1);
				end
			end
			default: ;
		endcase
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == vhm_pkg::S_IDLE) else $error("start while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> !res.done) else $error("done held");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vhm_pkg::S_BYTE) |-> idx_q < count) else $error("entry out of range");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vhm_pkg::S_BYTE) |-> k_q < n_q) else $error("byte index overrun");

endmodule

FILE: sim/vhm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhm_checker
// Watches the request, response and configuration channels of the virtual
// host matcher, keeps its own copy of the pattern table and host state,
// predicts one response word per closing request word and compares each
// accepted response word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vhm_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  vhm_pkg::req_t  req_word,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  vhm_pkg::rsp_t  rsp_word,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic           cfg_data,
	output int             errors,
	output int             pending
);

	localparam int N_ENT = vhm_pkg::MAX_ENTRIES_DEF;
	localparam int N_LEN = vhm_pkg::MAX_LEN_DEF;

	logic [7:0]    pat_mem [N_ENT][N_LEN];
	int            pat_len [N_ENT];
	bit            is_wild [N_ENT];
	int            n_stored;
	logic [7:0]    host_buf [N_LEN];
	int            hbuf_len;
	int            rbrk_at;
	int            colon_at;
	int            add_len;
	bit            has_default;
	vhm_pkg::rsp_t expected_rsps[$];

	function automatic logic [7:0] lower(logic [7:0] c);
		lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
	endfunction

	function automatic bit same_text(int slot, int pofs, int hofs, int n);
		for (int i = 0; i < n; i++)
			if (lower(pat_mem[slot][pofs + i]) != lower(host_buf[hofs + i]))
				return 0;
		return 1;
	endfunction

	task automatic push_rsp(vhm_pkg::outcome_t oc, int idx);
		vhm_pkg::rsp_t r;
		r.outcome     = oc;
		r.entry_index = idx[3:0];
		r.entry_count = n_stored[4:0];
		expected_rsps.push_back(r);
	endtask

	task automatic absorb_word(vhm_pkg::req_t w);
		int len;
		int sl;
		if (!w.req_type) begin
			if (w.byte_valid) begin
				if (n_stored < N_ENT && add_len < N_LEN)
					pat_mem[n_stored][add_len] = w.char_byte;
				if (add_len < N_LEN)
					add_len++;
			end
			if (!w.last)
				return;
			len = add_len;
			add_len = 0;
			if (n_stored >= N_ENT) begin
				push_rsp(vhm_pkg::OC_FULL, 0);
			end else if (len == 0 || len >= N_LEN) begin
				push_rsp(vhm_pkg::OC_BAD_LEN, 0);
			end else begin
				pat_len[n_stored] = len;
				is_wild[n_stored] = len >= 2 && pat_mem[n_stored][0] == vhm_pkg::CH_STAR &&
					pat_mem[n_stored][1] == vhm_pkg::CH_DOT;
				n_stored++;
				push_rsp(vhm_pkg::OC_ADDED, n_stored - 1);
			end
			return;
		end
		if (w.byte_valid && hbuf_len < N_LEN) begin
			host_buf[hbuf_len] = w.char_byte;
			if (w.char_byte == vhm_pkg::CH_RBRK && rbrk_at == 0)
				rbrk_at = hbuf_len + 1;
			if (w.char_byte == vhm_pkg::CH_COLON)
				colon_at = hbuf_len + 1;
			hbuf_len++;
		end
		if (!w.last)
			return;
		len = hbuf_len;
		if (len > 0) begin
			if (host_buf[0] == vhm_pkg::CH_LBRK) begin
				if (rbrk_at != 0)
					len = rbrk_at;
			end else if (colon_at != 0) begin
				len = colon_at - 1;
			end
		end
		hbuf_len = 0;
		rbrk_at  = 0;
		colon_at = 0;
		for (int i = 0; i < n_stored; i++)
			if (!is_wild[i] && pat_len[i] == len && same_text(i, 0, 0, len)) begin
				push_rsp(vhm_pkg::OC_EXACT, i);
				return;
			end
		for (int i = 0; i < n_stored; i++) begin
			sl = pat_len[i] - 1;
			if (is_wild[i] && len > sl && same_text(i, 1, len - sl, sl)) begin
				push_rsp(vhm_pkg::OC_WILDCARD, i);
				return;
			end
		end
		push_rsp(has_default ? vhm_pkg::OC_DEFAULT : vhm_pkg::OC_NOT_FOUND, 0);
	endtask

	initial begin
		errors   = 0;
		pending  = 0;
		n_stored = 0;
		hbuf_len = 0;
		rbrk_at  = 0;
		colon_at = 0;
		add_len  = 0;
		has_default = 0;
	end

	always @(posedge clk) begin
		vhm_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected response word %h", $time, rsp_word);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_word.outcome !== want.outcome ||
							rsp_word.entry_index !== want.entry_index ||
							rsp_word.entry_count !== want.entry_count) begin
						if (errors < 10)
							$display({"%0t: mismatch expected oc=%0d idx=%0d cnt=%0d",
								" got oc=%0d idx=%0d cnt=%0d"},
								$time, want.outcome, want.entry_index, want.entry_count,
								rsp_word.outcome, rsp_word.entry_index, rsp_word.entry_count);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				has_default = cfg_data;
			if (req_valid && !req_stall)
				absorb_word(req_word);
		end
		pending = expected_rsps.size();
	end

endmodule

FILE: sim/virtual_host_matcher_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_host_matcher_core_test
// Drives pattern adds and host lookups into the virtual host matcher with
// random gaps and response back-pressure, switches the default route between
// phases, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module virtual_host_matcher_core_test;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	vhm_pkg::req_t req_word;
	logic          rsp_valid;
	logic          rsp_stall;
	vhm_pkg::rsp_t rsp_word;
	logic          cfg_valid;
	logic          cfg_ready;
	logic          cfg_data;
	int            errors;
	int            pending;

	int   n_words;
	int   n_adds;
	int   n_lookups;
	bit   quiet;
	int   stall_left;
	int   table_fill;
	string stored_pats[$];

	virtual_host_matcher_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	vhm_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#40ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (quiet || p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (quiet) begin
			rsp_stall <= 1'b0;
		end else begin
			if ($urandom_range(99) < 70) begin
				rsp_stall <= 1'b0;
				stall_left <= $urandom_range(8);
			end else begin
				rsp_stall <= 1'b1;
				stall_left <= ($urandom_range(99) < 85) ? $urandom_range(3, 1) :
					$urandom_range(60, 20);
			end
		end
	end

	task automatic put_word(bit kind, logic [7:0] c, bit bv, bit fin);
		int g;
		bit st;
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= '{req_type: kind, char_byte: c, byte_valid: bv, last: fin};
		forever begin
			@(negedge clk);
			st = req_stall;
			@(posedge clk);
			if (!st)
				break;
		end
		n_words++;
	endtask

	// string sent byte by byte, with empty words and other-side words mixed in when noisy
	task automatic put_text(bit kind, string s, bit noisy);
		for (int i = 0; i < s.len(); i++) begin
			if (noisy && $urandom_range(99) < 4)
				put_word(kind, 8'($urandom_range(255)), 1'b0, 1'b0);
			if (noisy && $urandom_range(99) < 2)
				put_word(!kind, 8'($urandom_range(255)), 1'b0, 1'b1);
			put_word(kind, s[i], 1'b1, i == s.len() - 1 && !(noisy && $urandom_range(9) == 0));
		end
		if (s.len() == 0 || req_word.last !== 1'b1 || req_word.req_type !== kind)
			put_word(kind, 8'($urandom_range(255)), 1'b0, 1'b1);
		if (kind) n_lookups++; else n_adds++;
	endtask

	task automatic add_pattern(string s);
		if (s.len() > 0 && s.len() < 256 && table_fill < 16) begin
			table_fill++;
			stored_pats.push_back(s);
		end
		put_text(1'b0, s, 1'b1);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_default(bit v);
		bit rd;
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		forever begin
			@(negedge clk);
			rd = cfg_ready;
			@(posedge clk);
			if (rd)
				break;
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic byte pick_char();
		string abc;
		abc = "abcABC.-1";
		if ($urandom_range(99) < 90)
			return abc[$urandom_range(abc.len() - 1)];
		return byte'($urandom_range(255));
	endfunction

	function automatic string make_name();
		string s;
		int labels;
		s = "";
		labels = $urandom_range(3, 1);
		for (int l = 0; l < labels; l++) begin
			if (l > 0) s = {s, "."};
			repeat ($urandom_range(3, 1)) s = {s, string'(pick_char())};
		end
		return s;
	endfunction

	function automatic string flip_case(string s);
		for (int i = 0; i < s.len(); i++)
			if ($urandom_range(1) && ((s[i] >= "a" && s[i] <= "z") || (s[i] >= "A" && s[i] <= "Z")))
				s[i] = s[i] ^ 8'h20;
		return s;
	endfunction

	function automatic string make_host();
		string s;
		string p;
		int p100;
		p100 = $urandom_range(99);
		if (p100 < 5) begin
			s = "";
			repeat ($urandom_range(6)) s = {s, string'(byte'($urandom_range(255)))};
			return s;
		end
		if (p100 < 65 && stored_pats.size() > 0) begin
			p = stored_pats[$urandom_range(stored_pats.size() - 1)];
			if (p.len() >= 2 && p[0] == "*" && p[1] == ".")
				s = ($urandom_range(9) == 0) ? p.substr(1, p.len() - 1) :
					{make_name(), p.substr(1, p.len() - 1)};
			else
				s = p;
			s = flip_case(s);
		end else begin
			s = make_name();
		end
		p100 = $urandom_range(99);
		if (p100 < 10)
			s = {"[", s, "]", ($urandom_range(1) ? string'(":80") : string'(""))};
		else if (p100 < 40)
			s = {s, ":", $sformatf("%0d", $urandom_range(9999))};
		else if (p100 < 43)
			s = {s, "::"};
		return s;
	endfunction

	initial begin
		string longs;
		int ph_base;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req_word   = '0;
		rsp_stall  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = 1'b0;
		stall_left = 0;
		quiet      = 0;
		n_words    = 0;
		n_adds     = 0;
		n_lookups  = 0;
		table_fill = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		write_default(1'b0);
		put_word(1'b1, 8'h00, 1'b0, 1'b1);
		put_word(1'b0, 8'hff, 1'b0, 1'b1);
		add_pattern("*.a");
		add_pattern({8'h00, 8'hff});
		add_pattern("[B]");
		put_text(1'b1, {8'h00, 8'hff}, 1'b0);
		put_text(1'b1, "[b]:1", 1'b0);
		put_text(1'b1, "z.A", 1'b0);
		put_text(1'b1, ".a", 1'b0);
		write_default(1'b1);
		put_text(1'b1, "q:", 1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			quiet = (ph == 2);
			if (ph == 1) begin
				longs = "";
				repeat (300) longs = {longs, "a"};
				add_pattern(longs);
				put_text(1'b1, longs, 1'b0);
				add_pattern(longs.substr(0, 254));
				put_text(1'b1, {longs.substr(0, 254), ":9"}, 1'b0);
			end
			ph_base = n_words;
			while (n_words < ph_base + 130) begin
				if ($urandom_range(99) < ((table_fill < 16) ? 35 : 8))
					add_pattern(($urandom_range(3) == 0) ? {"*.", make_name()} : make_name());
				else
					put_text(1'b1, make_host(), 1'b1);
			end
			write_default(ph[0]);
		end

		wait_idle();
		repeat (50) @(posedge clk);
		$display("Covered %0d request words: %0d adds and %0d lookups,", n_words, n_adds,
			n_lookups);
		$display("exact, wildcard, port-stripped, long and empty strings under back-pressure.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: virtual_host_matcher_core.f
rtl/core/vhm_pkg.sv
rtl/core/vhm_store.sv
rtl/core/vhm_match_seq.sv
rtl/core/virtual_host_matcher_core.sv
sim/vhm_checker.sv
sim/virtual_host_matcher_core_test.sv
